// File: hdl/rpb_pkg.sv
package rpb_pkg;

  // Pixel layout: three 5-bit channels, blue at the bottom, plus a top flag bit.
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned NUM_CHAN = 3;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 2'd1;

  // Opacity is a percentage; writes above the top value saturate.
  localparam logic [CFG_DATA_W-1:0] OPACITY_MAX = 7'd100;

  // Widths of the intermediate values.
  localparam int unsigned PROD_W   = 12;  // up to 31 * 100
  localparam int unsigned SCR_P_W  = 9;   // (32 - m) * n stays at or below 256
  localparam int unsigned DIV100_W = 23;
  localparam int unsigned DIV110_W = 25;

  // Division by 100 and by 110 as multiply by a scaled reciprocal and shift.
  // Both are exact for every dividend up to 31 * 100.
  localparam logic [10:0] RECIP_100    = 11'd1311;
  localparam int unsigned DIV100_SHIFT = 17;
  localparam logic [12:0] RECIP_110    = 13'd4767;
  localparam int unsigned DIV110_SHIFT = 19;

  // Grayscale channel weights.
  localparam logic [PROD_W-1:0] GRAY_WR = 12'd30;
  localparam logic [PROD_W-1:0] GRAY_WG = 12'd59;
  localparam logic [PROD_W-1:0] GRAY_WB = 12'd11;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;

  typedef enum logic [1:0] {
    MODE_COPY   = 2'd0,
    MODE_SCREEN = 2'd1,
    MODE_GRAY   = 2'd2,
    MODE_ALPHA  = 2'd3
  } blend_mode_t;

  // First stage, per channel: raw products, the screen zero flag and the larger channel.
  typedef struct packed {
    logic [PROD_W-1:0]  alpha_src;
    logic [PROD_W-1:0]  alpha_dst;
    logic               scr_zero;
    logic [CHAN_W-1:0]  scr_max;
    logic [SCR_P_W-1:0] scr_prod;
  } mul_chan_t;

  typedef struct packed {
    blend_mode_t            mode;
    logic [PIX_W-1:0]       src;
    mul_chan_t [NUM_CHAN-1:0] ch;
    logic [PROD_W-1:0]      gray_sum;
  } mul_stage_t;

  // Second stage, per channel: quotients and the finished screen value.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha_src;
    logic [CHAN_W-1:0] alpha_dst;
    logic [CHAN_W-1:0] screen;
  } div_chan_t;

  typedef struct packed {
    blend_mode_t            mode;
    logic [PIX_W-1:0]       src;
    div_chan_t [NUM_CHAN-1:0] ch;
    logic [CHAN_W-1:0]      gray;
  } div_stage_t;

endpackage

// File: hdl/rpb_in_if.sv
interface rpb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] src_pixel;
  logic [15:0] dst_pixel;

  modport source (output valid, output src_pixel, output dst_pixel, input ready);
  modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

// File: hdl/rpb_out_if.sv
interface rpb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pixel;

  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface

// File: hdl/rpb_mul_stage.sv
module rpb_mul_stage (
  input  rpb_pkg::blend_mode_t            mode,
  input  logic [rpb_pkg::CFG_DATA_W-1:0]  opacity,
  input  logic [rpb_pkg::PIX_W-1:0]       src,
  input  logic [rpb_pkg::PIX_W-1:0]       dst,
  output rpb_pkg::mul_stage_t             stage
);

  logic [rpb_pkg::CFG_DATA_W-1:0] inv_opacity;
  logic [rpb_pkg::CHAN_W-1:0]     s_ch [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::CHAN_W-1:0]     d_ch [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::CHAN_W-1:0]     hi   [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::CHAN_W-1:0]     lo   [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::CHAN_W:0]       gap  [rpb_pkg::NUM_CHAN];

  // Destination weight is the complement of the opacity percentage.
  assign inv_opacity = rpb_pkg::OPACITY_MAX - opacity;

  // Per-channel products for screen and alpha; each channel is independent.
  always_comb begin
    stage.mode = mode;
    stage.src  = src;
    for (int c = 0; c < rpb_pkg::NUM_CHAN; c++) begin
      s_ch[c] = src[c*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W];
      d_ch[c] = dst[c*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W];
      hi[c]   = (s_ch[c] > d_ch[c]) ? s_ch[c] : d_ch[c];
      lo[c]   = (s_ch[c] > d_ch[c]) ? d_ch[c] : s_ch[c];
      gap[c]  = 6'd32 - {1'b0, hi[c]};
      stage.ch[c].scr_zero  = (s_ch[c] == '0) || (d_ch[c] == '0);
      stage.ch[c].scr_max   = hi[c];
      stage.ch[c].scr_prod  = rpb_pkg::SCR_P_W'({5'd0, gap[c]} * {6'd0, lo[c]});
      stage.ch[c].alpha_src = {7'd0, s_ch[c]} * {5'd0, opacity};
      stage.ch[c].alpha_dst = {7'd0, d_ch[c]} * {5'd0, inv_opacity};
    end
    // Weighted luminance sum of the source.
    stage.gray_sum = rpb_pkg::GRAY_WR * {7'd0, src[14:10]}
                   + rpb_pkg::GRAY_WG * {7'd0, src[9:5]}
                   + rpb_pkg::GRAY_WB * {7'd0, src[4:0]};
  end

endmodule

// File: hdl/rpb_div_stage.sv
module rpb_div_stage (
  input  rpb_pkg::mul_stage_t prev,
  output rpb_pkg::div_stage_t stage
);

  logic [rpb_pkg::DIV100_W-1:0] q_src [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::DIV100_W-1:0] q_dst [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::CHAN_W:0]     scr_sum [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::DIV110_W-1:0] q_gray;

  // Alpha quotients by reciprocal multiply, screen add and saturate.
  always_comb begin
    stage.mode = prev.mode;
    stage.src  = prev.src;
    for (int c = 0; c < rpb_pkg::NUM_CHAN; c++) begin
      q_src[c] = {11'd0, prev.ch[c].alpha_src} * {12'd0, rpb_pkg::RECIP_100};
      q_dst[c] = {11'd0, prev.ch[c].alpha_dst} * {12'd0, rpb_pkg::RECIP_100};
      stage.ch[c].alpha_src = q_src[c][rpb_pkg::DIV100_SHIFT +: rpb_pkg::CHAN_W];
      stage.ch[c].alpha_dst = q_dst[c][rpb_pkg::DIV100_SHIFT +: rpb_pkg::CHAN_W];
      scr_sum[c] = {1'b0, prev.ch[c].scr_max} + {2'b0, prev.ch[c].scr_prod[8:5]};
      if (prev.ch[c].scr_zero) begin
        stage.ch[c].screen = '0;
      end else if (scr_sum[c] > {1'b0, rpb_pkg::CHAN_MAX}) begin
        stage.ch[c].screen = rpb_pkg::CHAN_MAX;
      end else begin
        stage.ch[c].screen = scr_sum[c][rpb_pkg::CHAN_W-1:0];
      end
    end
    // Gray level: divide the weighted sum by 110.
    q_gray     = {13'd0, prev.gray_sum} * {12'd0, rpb_pkg::RECIP_110};
    stage.gray = q_gray[rpb_pkg::DIV110_SHIFT +: rpb_pkg::CHAN_W];
  end

endmodule

// File: hdl/rpb_pack.sv
module rpb_pack (
  input  rpb_pkg::div_stage_t       prev,
  output logic [rpb_pkg::PIX_W-1:0] pixel
);

  logic [rpb_pkg::CHAN_W:0] alpha_sum [rpb_pkg::NUM_CHAN];
  logic [rpb_pkg::CHAN_W-1:0] alpha_ch [rpb_pkg::NUM_CHAN];

  // The two alpha quotients never sum above the channel maximum.
  always_comb begin
    for (int c = 0; c < rpb_pkg::NUM_CHAN; c++) begin
      alpha_sum[c] = {1'b0, prev.ch[c].alpha_src} + {1'b0, prev.ch[c].alpha_dst};
      alpha_ch[c]  = alpha_sum[c][rpb_pkg::CHAN_W-1:0];
    end
  end

  // Select the result by mode; every blended mode sets the top bit.
  always_comb begin
    unique case (prev.mode)
      rpb_pkg::MODE_COPY: begin
        pixel = prev.src;
      end
      rpb_pkg::MODE_SCREEN: begin
        pixel = {1'b1, prev.ch[2].screen, prev.ch[1].screen, prev.ch[0].screen};
      end
      rpb_pkg::MODE_GRAY: begin
        pixel = {1'b1, prev.gray, prev.gray, prev.gray};
      end
      rpb_pkg::MODE_ALPHA: begin
        pixel = {1'b1, alpha_ch[2], alpha_ch[1], alpha_ch[0]};
      end
      default: begin
        pixel = prev.src;
      end
    endcase
  end

endmodule

// File: hdl/rgb555_pixel_blend.sv
// An accepted request passes the product, divide and pack registers on its way to the blended output.
// Throughput: one pixel pair per cycle; the three register stages (products,
// reciprocal divide, select and pack) all advance together on a free output.
// Reset (synchronous, active high) empties the pipeline and sets the blend
// mode to copy and the opacity to 100.
module rgb555_pixel_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpb_pkg::CFG_DATA_W-1:0]  cfg_data,
  rpb_in_if.sink                          pixels,
  rpb_out_if.source                       blended
);

  rpb_pkg::blend_mode_t           mode;
  logic [rpb_pkg::CFG_DATA_W-1:0] opacity;

  rpb_pkg::mul_stage_t mul_next;
  rpb_pkg::mul_stage_t mul_q;
  rpb_pkg::div_stage_t div_next;
  rpb_pkg::div_stage_t div_q;
  logic [rpb_pkg::PIX_W-1:0] pixel_next;
  logic [rpb_pkg::PIX_W-1:0] pixel_q;
  logic                      mul_valid;
  logic                      div_valid;
  logic                      out_valid;
  logic                      advance;

  // The whole pipeline moves whenever the output stage is empty or being taken.
  assign advance      = !out_valid || blended.ready;
  assign pixels.ready = advance;

  assign blended.valid     = out_valid;
  assign blended.out_pixel = pixel_q;

  // Configuration registers; opacity saturates at 100.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= rpb_pkg::MODE_COPY;
      opacity <= rpb_pkg::OPACITY_MAX;
    end else if (cfg_we) begin
      if (cfg_index == rpb_pkg::REG_BLEND_MODE) begin
        mode <= rpb_pkg::blend_mode_t'(cfg_data[1:0]);
      end else if (cfg_index == rpb_pkg::REG_OPACITY) begin
        opacity <= (cfg_data > rpb_pkg::OPACITY_MAX) ? rpb_pkg::OPACITY_MAX : cfg_data;
      end
    end
  end

  rpb_mul_stage u_mul (
    .mode    (mode),
    .opacity (opacity),
    .src     (pixels.src_pixel),
    .dst     (pixels.dst_pixel),
    .stage   (mul_next)
  );

  rpb_div_stage u_div (
    .prev  (mul_q),
    .stage (div_next)
  );

  rpb_pack u_pack (
    .prev  (div_q),
    .pixel (pixel_next)
  );

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      div_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= pixels.valid;
      div_valid <= mul_valid;
      out_valid <= div_valid;
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      mul_q   <= mul_next;
      div_q   <= div_next;
      pixel_q <= pixel_next;
    end
  end

endmodule

// File: hdl/rpb_checker.sv
module rpb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel
);

  // The output register is empty on the cycle after a reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // A new request can be taken exactly when the output stage is empty or being taken.
  assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stage");

  // With the output ready while it moves, an accepted request reaches the output as a valid result.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing three cycles after the request");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel)))
    else $error("stalled result changed");

endmodule

bind rgb555_pixel_blend rpb_checker u_rpb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (blended.valid),
  .out_ready (blended.ready),
  .out_pixel (blended.out_pixel)
);

// File: sim/tb_rgb555_pixel_blend.sv
`timescale 1ns / 1ps

module tb_rgb555_pixel_blend;

  // Indexes past the end of the register list; writes to them must be ignored.
  localparam logic [rpb_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [rpb_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int PIPE_LATENCY   = 3;
  localparam int PHASE_REQUESTS = 47;
  localparam int NUM_PHASES     = 16;

  typedef struct packed {
    logic [rpb_pkg::PIX_W-1:0] src;
    logic [rpb_pkg::PIX_W-1:0] dst;
  } pixel_pair_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [rpb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rpb_pkg::CFG_DATA_W-1:0] cfg_data;

  rpb_in_if  pixels_if ();
  rpb_out_if blended_if ();

  rgb555_pixel_blend i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels_if),
    .blended   (blended_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the blend registers, plus the request and result queues.
  rpb_pkg::blend_mode_t           model_mode    = rpb_pkg::MODE_COPY;
  logic [rpb_pkg::CFG_DATA_W-1:0] model_opacity = rpb_pkg::OPACITY_MAX;
  pixel_pair_t                    pending_pairs[$];
  logic [rpb_pkg::PIX_W-1:0]      expected_pixels[$];
  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  int                             pixels_checked = 0;
  int                             mismatch_count = 0;
  int                             settings_run = 0;

  // Blends one pixel pair under the current shadow registers.
  function automatic logic [rpb_pkg::PIX_W-1:0] blend_pixel(
      input logic [rpb_pkg::PIX_W-1:0] src,
      input logic [rpb_pkg::PIX_W-1:0] dst);
    int unsigned s, d, hi, lo, v, gray, op;
    logic [rpb_pkg::PIX_W-1:0] res;
    res = 16'h8000;
    op  = model_opacity;
    case (model_mode)
      rpb_pkg::MODE_COPY: begin
        res = src;
      end
      rpb_pkg::MODE_GRAY: begin
        gray = (30 * src[14:10] + 59 * src[9:5] + 11 * src[4:0]) / 110;
        res[14:0] = {3{gray[4:0]}};
      end
      default: begin
        for (int k = 0; k < rpb_pkg::NUM_CHAN; k++) begin
          s = (src >> (rpb_pkg::CHAN_W * k)) & 32'h1F;
          d = (dst >> (rpb_pkg::CHAN_W * k)) & 32'h1F;
          if (model_mode == rpb_pkg::MODE_SCREEN) begin
            // A zero channel on either side gives zero, not the other side.
            if (s == 0 || d == 0) begin
              v = 0;
            end else begin
              hi = (s > d) ? s : d;
              lo = (s > d) ? d : s;
              v  = hi + (((32 - hi) * lo) >> 5);
              if (v > 31) v = 31;
            end
          end else begin
            v = (s * op) / 100 + (d * (100 - op)) / 100;
          end
          res[rpb_pkg::CHAN_W*k +: rpb_pkg::CHAN_W] = v[4:0];
        end
      end
    endcase
    return res;
  endfunction

  // Channels lean toward zero and full scale so the screen corner cases come up often.
  function automatic logic [rpb_pkg::PIX_W-1:0] rand_pixel();
    logic [rpb_pkg::PIX_W-1:0] p;
    p[15] = 1'($urandom_range(0, 1));
    for (int k = 0; k < rpb_pkg::NUM_CHAN; k++) begin
      case ($urandom_range(0, 7))
        0:       p[rpb_pkg::CHAN_W*k +: rpb_pkg::CHAN_W] = 5'd0;
        1:       p[rpb_pkg::CHAN_W*k +: rpb_pkg::CHAN_W] = rpb_pkg::CHAN_MAX;
        default: p[rpb_pkg::CHAN_W*k +: rpb_pkg::CHAN_W] = 5'($urandom());
      endcase
    end
    return p;
  endfunction

  // Request driver: predicts each accepted pair, then loads the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      pixels_if.valid <= 1'b0;
    end else begin
      if (pixels_if.valid && pixels_if.ready) begin
        expected_pixels.push_back(blend_pixel(pixels_if.src_pixel, pixels_if.dst_pixel));
      end
      if (!pixels_if.valid || pixels_if.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pixels_if.valid     <= 1'b1;
          pixels_if.src_pixel <= pending_pairs[0].src;
          pixels_if.dst_pixel <= pending_pairs[0].dst;
          pending_pairs.pop_front();
        end else begin
          pixels_if.valid     <= 1'b0;
          pixels_if.src_pixel <= 16'($urandom());
          pixels_if.dst_pixel <= 16'($urandom());
        end
      end
    end
  end

  // Result monitor: compares each accepted pixel with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      blended_if.ready <= 1'b0;
    end else begin
      if (blended_if.valid && blended_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %h with nothing outstanding",
                   $realtime, blended_if.out_pixel);
          mismatch_count++;
        end else begin
          if (blended_if.out_pixel !== expected_pixels[0]) begin
            $display("%0t: pixel mismatch, expected %h, actual %h",
                     $realtime, expected_pixels[0], blended_if.out_pixel);
            mismatch_count++;
          end
          expected_pixels.pop_front();
          pixels_checked++;
        end
      end
      blended_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Register write; the shadow copy follows the same index decode and saturation.
  task automatic write_reg(input logic [rpb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpb_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == rpb_pkg::REG_BLEND_MODE) begin
      model_mode = rpb_pkg::blend_mode_t'(data[1:0]);
    end else if (idx == rpb_pkg::REG_OPACITY) begin
      model_opacity = (data > rpb_pkg::OPACITY_MAX) ? rpb_pkg::OPACITY_MAX : data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every request has gone through and its pixel has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_pairs.size() != 0 || pixels_if.valid || expected_pixels.size() != 0);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  // Edge pixels: all zero, all ones, flag bits alone, single channels, mixed levels.
  task automatic push_directed();
    pending_pairs.push_back('{16'h0000, 16'h0000});
    pending_pairs.push_back('{16'hFFFF, 16'hFFFF});
    pending_pairs.push_back('{16'h7FFF, 16'h0000});
    pending_pairs.push_back('{16'h8000, 16'h7FFF});
    pending_pairs.push_back('{16'h7C1F, 16'h83E0});
    pending_pairs.push_back('{16'h0421, 16'h5AD6});
    settings_run++;
  endtask

  initial begin
    logic [rpb_pkg::CFG_DATA_W-1:0] opa;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = rpb_pkg::REG_BLEND_MODE;
    cfg_data             = '0;
    pixels_if.valid      = 1'b0;
    pixels_if.src_pixel  = '0;
    pixels_if.dst_pixel  = '0;
    blended_if.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass: copy and alpha at their reset values, then every other mode.
    push_directed();
    wait_drained();
    write_reg(rpb_pkg::REG_BLEND_MODE, {5'h1F, rpb_pkg::MODE_ALPHA});
    push_directed();
    wait_drained();
    write_reg(REG_SPARE_2, 7'h7F);
    write_reg(REG_SPARE_3, 7'h00);
    write_reg(rpb_pkg::REG_BLEND_MODE, {5'h0A, rpb_pkg::MODE_SCREEN});
    push_directed();
    wait_drained();
    write_reg(rpb_pkg::REG_BLEND_MODE, {5'h00, rpb_pkg::MODE_GRAY});
    push_directed();
    wait_drained();

    // Random phases: each idle pattern is paired with every mode.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  opa = 7'd0;   end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  opa = 7'd127; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; opa = 7'd1;   end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
          opa            = 7'($urandom_range(0, 127));
        end
      endcase
      write_reg(rpb_pkg::REG_BLEND_MODE, {5'($urandom()), rpb_pkg::blend_mode_t'(p % 4)});
      write_reg(rpb_pkg::REG_OPACITY, opa);
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 7'($urandom()));
      end
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        pending_pairs.push_back('{rand_pixel(), rand_pixel()});
      end
      settings_run++;
      wait_drained();
    end

    repeat (2 * PIPE_LATENCY) @(negedge clk);
    $display("Compared %0d blended pixels across %0d register settings,", pixels_checked,
             settings_run);
    $display("covering all four blend modes with and without source and sink back-pressure.");
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d pixels still outstanding", expected_pixels.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
hdl/rpb_pkg.sv
hdl/rpb_in_if.sv
hdl/rpb_out_if.sv
hdl/rpb_mul_stage.sv
hdl/rpb_div_stage.sv
hdl/rpb_pack.sv
hdl/rgb555_pixel_blend.sv
hdl/rpb_checker.sv
sim/tb_rgb555_pixel_blend.sv
